// ===== hdl/smv_pkg.sv =====
// smv_pkg: types and constants shared by the half-step stepper sequencer
// holds the command/result payload structs, operation codes and the coil table
// no dependencies
`default_nettype none

package smv_pkg;

    // operation codes
    localparam logic [1:0] OP_TICK       = 2'd0;
    localparam logic [1:0] OP_MOVE_STEPS = 2'd1;
    localparam logic [1:0] OP_MOVE_DEG   = 2'd2;

    // steps-per-revolution after reset
    localparam logic [15:0] SPR_RESET = 16'd4096;

    // divide by 360 as shift by 3, then multiply by ceil(2^35 / 45)
    // exact for any 29-bit dividend
    localparam int          DEG_PRE_SHIFT = 3;
    localparam int          RECIP_SHIFT   = 35;
    localparam logic [29:0] RECIP_45      = 30'd763549742;

    // input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] amount;
        logic        direction;
        logic [15:0] step_delay;
    } smv_in_t;

    // result item
    typedef struct packed {
        logic [3:0]  coil_pattern;
        logic [2:0]  phase_now;
        logic        busy_res;
        logic [15:0] steps_left;
        logic        rejected;
    } smv_out_t;

    // command after degree scaling, step count resolved
    typedef struct packed {
        logic [1:0]  operation;
        logic        direction;
        logic [15:0] step_delay;
        logic [15:0] count;
    } smv_cmd_t;

    // half-step coil drive for each phase
    function automatic logic [3:0] coil_of(input logic [2:0] ph);
        logic [3:0] pat;
        unique case (ph)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h3;
            3'd2: pat = 4'h2;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'hC;
            3'd6: pat = 4'h8;
            3'd7: pat = 4'h9;
            default: pat = 4'h1;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/smv_deg_scale.sv =====
// smv_deg_scale: two-stage pipeline turning a command into a resolved step count
// degrees * steps_per_rev in stage one, reciprocal divide by 360 in stage two
// depends on smv_pkg
`default_nettype none

module smv_deg_scale
    import smv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] steps_per_rev,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire smv_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output smv_cmd_t         out_data
);

    logic        a_valid_reg;
    smv_in_t     a_data_reg;
    logic [31:0] a_prod_reg;
    logic        b_valid_reg;
    smv_cmd_t    b_cmd_reg;

    logic        a_ready;
    logic        b_ready;
    logic [28:0] div_in;
    logic [58:0] recip_prod;
    logic [15:0] quot;
    smv_cmd_t    b_cmd_next;

    // per-stage ready so bubbles collapse while the output stalls
    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    // stage one valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // stage one payload and degree product
    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            a_data_reg <= in_data;
            a_prod_reg <= in_data.amount * steps_per_rev;
        end
    end

    // divide by 360: drop three bits, multiply by reciprocal of 45
    assign div_in     = a_prod_reg[31:DEG_PRE_SHIFT];
    assign recip_prod = 59'(div_in) * 59'(RECIP_45);
    assign quot       = recip_prod[RECIP_SHIFT +: 16];

    // resolved command
    always_comb
    begin
        b_cmd_next.operation  = a_data_reg.operation;
        b_cmd_next.direction  = a_data_reg.direction;
        b_cmd_next.step_delay = a_data_reg.step_delay;
        b_cmd_next.count      = (a_data_reg.operation == OP_MOVE_DEG) ? quot
                                                                      : a_data_reg.amount;
    end

    // stage two valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage two payload
    always_ff @(posedge clk)
    begin
        if (a_valid_reg && b_ready)
        begin
            b_cmd_reg <= b_cmd_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_cmd_reg;

endmodule

`default_nettype wire

// ===== hdl/smv_step_core.sv =====
// smv_step_core: phase, step count and wait state of the sequencer, plus result register
// applies ticks and moves one per cycle while results are taken
// depends on smv_pkg
`default_nettype none

module smv_step_core
    import smv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire smv_cmd_t cmd_data,
    output logic          res_valid,
    input  wire logic     res_ready,
    output smv_out_t      res_data
);

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [15:0] wait_reg;
    logic [15:0] wait_next;
    logic        dir_reg;
    logic        dir_next;
    logic [15:0] dly_reg;
    logic [15:0] dly_next;
    logic        res_valid_reg;
    smv_out_t    res_reg;
    smv_out_t    res_next;

    logic        accept;
    logic        busy;
    logic        do_step;
    logic        rejected;
    logic [15:0] wait_dec;
    logic [15:0] step_rem;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign busy      = (rem_reg != 16'd0) || (wait_reg != 16'd0);
    assign wait_dec  = wait_reg - 16'd1;

    // decode the command against current state
    always_comb
    begin
        do_step  = 1'b0;
        rejected = 1'b0;
        dir_next = dir_reg;
        dly_next = dly_reg;
        step_rem = rem_reg;
        unique case (cmd_data.operation)
            OP_TICK:
            begin
                if (wait_reg != 16'd0)
                begin
                    do_step = (wait_dec == 16'd0) && (rem_reg != 16'd0);
                end
            end
            OP_MOVE_STEPS, OP_MOVE_DEG:
            begin
                if (busy)
                begin
                    rejected = 1'b1;
                end
                else if (cmd_data.count != 16'd0)
                begin
                    do_step  = 1'b1;
                    dir_next = cmd_data.direction;
                    dly_next = cmd_data.step_delay;
                    step_rem = cmd_data.count;
                end
            end
            default:
            begin
                do_step = 1'b0;
            end
        endcase
    end

    // take a step or count the wait down
    always_comb
    begin
        if (do_step)
        begin
            phase_next = dir_next ? (phase_reg + 3'd1) : (phase_reg - 3'd1);
            rem_next   = step_rem - 16'd1;
            wait_next  = (dly_next == 16'd0) ? 16'd1 : dly_next;
        end
        else
        begin
            phase_next = phase_reg;
            rem_next   = rem_reg;
            wait_next  = ((cmd_data.operation == OP_TICK) && (wait_reg != 16'd0)) ? wait_dec
                                                                                  : wait_reg;
        end
    end

    // result from the updated state
    always_comb
    begin
        res_next.coil_pattern = coil_of(phase_next);
        res_next.phase_now    = phase_next;
        res_next.busy_res     = (rem_next != 16'd0) || (wait_next != 16'd0);
        res_next.steps_left   = rem_next;
        res_next.rejected     = rejected;
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            rem_reg   <= 16'd0;
            wait_reg  <= 16'd0;
            dir_reg   <= 1'b0;
            dly_reg   <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            wait_reg  <= wait_next;
            dir_reg   <= dir_next;
            dly_reg   <= dly_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            res_valid_reg <= cmd_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // a rejected move leaves the motion state alone
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && rejected) |=> ($stable(phase_reg) && $stable(rem_reg) && $stable(wait_reg)))
        else $error("rejected move changed sequencer state");

    // phase moves at most one place per transfer
    a_phase_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((phase_reg == $past(phase_reg))
                    || (phase_reg == ($past(phase_reg) + 3'd1))
                    || (phase_reg == ($past(phase_reg) - 3'd1))))
        else $error("phase jumped more than one half-step");

    // shown coil pattern belongs to the shown phase
    a_coil_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.coil_pattern == coil_of(res_reg.phase_now)))
        else $error("coil pattern does not match phase");

    // result phase tracks the live phase register after a transfer
    a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (res_reg.phase_now == phase_reg))
        else $error("result phase differs from state");

endmodule

`default_nettype wire

// ===== hdl/stepper_half_step_mover_unit.sv =====
// stepper_half_step_mover_unit: top level of the four-coil half-step sequencer
// holds the steps_per_rev register and joins the scaling pipeline to the step core
// depends on smv_pkg, smv_deg_scale, smv_step_core
`default_nettype none

// Takes one command per clock (tick, move by steps, move by degrees) and returns
// exactly one result per command: the coil drive, the phase, busy, the steps left
// and a flag for a move rejected while busy. Throughput is one item per cycle
// while results are taken; a command passes the registered product and divide
// stages of the degree scaling path (a 16x16 product, then a reciprocal multiply
// for the divide by 360) and then the state and result registers. Bubbles collapse,
// so commands fill empty stages while a result waits. steps_per_rev is written
// through the cfg channel, always ready, and should only change while no command is in flight.
module stepper_half_step_mover_unit
    import smv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire smv_in_t     cmd_data,
    output logic             res_valid,
    input  wire logic        res_ready,
    output smv_out_t         res_data
);

    logic [15:0] spr_reg;
    logic        mid_valid;
    logic        mid_ready;
    smv_cmd_t    mid_cmd;

    assign cfg_ready = 1'b1;

    // steps-per-revolution register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            spr_reg <= cfg_data;
        end
    end

    // degree scaling pipeline
    smv_deg_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .steps_per_rev (spr_reg),
        .in_valid      (cmd_valid),
        .in_ready      (cmd_ready),
        .in_data       (cmd_data),
        .out_valid     (mid_valid),
        .out_ready     (mid_ready),
        .out_data      (mid_cmd)
    );

    // sequencer state and result register
    smv_step_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (mid_valid),
        .cmd_ready (mid_ready),
        .cmd_data  (mid_cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire
